>>> rtl/eeseq_pkg.sv
// Shared types, codes and constants of the EEPROM access sequencer.
// Depends on nothing; every other file takes names from here by scope.
`default_nettype none

package eeseq_pkg;

    // Width of the address and length fields on the ports
    localparam int ADDR_FIELD_W = 16;
    localparam int ADDR_WIDTH_DEF = 16;
    // Results one input word can cause, and depth of the queue between the halves
    localparam int MAX_RES = 4;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CHIP_SIZE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_LOG2 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_WR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_RD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TWO_BYTE = 3'd4;

    typedef enum logic [2:0] {
        OP_READ_REQ  = 3'd0,
        OP_WRITE_REQ = 3'd1,
        OP_WR_DATA   = 3'd2,
        OP_BUS_ACK   = 3'd3,
        OP_BUS_READ  = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        CMD_START = 4'd0,
        CMD_WRITE = 4'd1,
        CMD_RACK  = 4'd2,
        CMD_RNACK = 4'd3,
        CMD_STOP  = 4'd4,
        CMD_WAIT  = 4'd5,
        CMD_DATA  = 4'd6,
        CMD_DONE  = 4'd7,
        CMD_NEED  = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_RD_NACK  = 2'd2,
        ST_WR_FAIL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RD_CTRL   = 4'd1,
        PH_RD_AHI    = 4'd2,
        PH_RD_ALO    = 4'd3,
        PH_RD_CTRLRD = 4'd4,
        PH_RD_DATA   = 4'd5,
        PH_WR_CTRL   = 4'd6,
        PH_WR_AHI    = 4'd7,
        PH_WR_ALO    = 4'd8,
        PH_WR_NEED   = 4'd9,
        PH_WR_DACK   = 4'd10
    } phase_t;

    // One bus command or host notice
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] byte_value;
        status_t    status;
    } res_t;

    // All results of one input word; last_idx marks the final entry
    typedef struct packed {
        logic [1:0]          last_idx;
        res_t [MAX_RES-1:0]  ent;
    } burst_t;

    // Configuration as seen by the front end
    typedef struct packed {
        logic [16:0] chip_size;
        logic [3:0]  page_log2;
        logic [7:0]  ctrl_wr;
        logic [7:0]  ctrl_rd;
        logic        two_byte;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/eeseq_front.sv
// Front end: takes input words, runs the access state and builds the burst
// of results each word causes. Uses eeseq_pkg.
`default_nettype none

module eeseq_front #(
    parameter int ADDR_WIDTH = eeseq_pkg::ADDR_WIDTH_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire eeseq_pkg::cfg_t     cfg,
    input  wire                      accept,
    input  wire [2:0]                operation,
    input  wire [15:0]               address,
    input  wire [15:0]               length,
    input  wire [7:0]                data_byte,
    input  wire                      ack,
    output logic                     q_push,
    output eeseq_pkg::burst_t        q_data
);

    eeseq_pkg::phase_t       phase_reg, phase_next;
    logic [ADDR_WIDTH-1:0]   addr_reg, addr_next;
    logic [15:0]             rem_reg, rem_next;
    logic [8:0]              pbl_reg, pbl_next;

    logic [ADDR_WIDTH-1:0]   req_addr;
    logic [15:0]             req_addr16;
    logic [15:0]             cur_addr16;
    logic [ADDR_WIDTH:0]     addr_inc;
    logic [ADDR_WIDTH-1:0]   wrap_addr;
    logic [15:0]             wrap_addr16;
    logic [15:0]             rem_dec;
    logic [8:0]              pbl_dec;
    logic [2:0]              n_res;

    function automatic eeseq_pkg::res_t mk(input eeseq_pkg::cmd_t c, input logic [7:0] b,
                                           input eeseq_pkg::status_t s);
        eeseq_pkg::res_t r;
        r.cmd = c;
        r.byte_value = b;
        r.status = s;
        return r;
    endfunction

    // Merge the high address bits into the control byte unless sent apart
    function automatic logic [7:0] ctrl_byte(input logic [7:0] base, input logic two,
                                             input logic [7:0] ahi);
        return two ? base : base + {ahi[6:0], 1'b0};
    endfunction

    // Bytes up to the next page boundary, capped by what is left
    function automatic logic [8:0] chunk(input logic [3:0] lg, input logic [7:0] off,
                                         input logic [15:0] rem);
        logic [3:0] lg_c;
        logic [8:0] page;
        logic [8:0] room;
        lg_c = (lg > 4'd8) ? 4'd8 : lg;
        page = 9'd1 << lg_c;
        room = page - ({1'b0, off} & (page - 9'd1));
        return ({7'd0, room} > rem) ? rem[8:0] : room;
    endfunction

    // Address helpers
    assign req_addr    = address[ADDR_WIDTH-1:0];
    assign req_addr16  = 16'(req_addr);
    assign cur_addr16  = 16'(addr_reg);
    assign addr_inc    = {1'b0, addr_reg} + {{ADDR_WIDTH{1'b0}}, 1'b1};
    assign wrap_addr   = (17'(addr_inc) >= cfg.chip_size) ? '0 : addr_inc[ADDR_WIDTH-1:0];
    assign wrap_addr16 = 16'(wrap_addr);
    assign rem_dec     = rem_reg - 16'd1;
    assign pbl_dec     = pbl_reg - 9'd1;

    // Advance the access state and collect the results of one word
    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        pbl_next   = pbl_reg;
        n_res      = 3'd0;
        q_data     = '0;
        unique case (operation)
            eeseq_pkg::OP_READ_REQ, eeseq_pkg::OP_WRITE_REQ:
            begin
                if (phase_reg == eeseq_pkg::PH_IDLE)
                begin
                    if ({1'b0, address} >= cfg.chip_size)
                    begin
                        q_data.ent[0] = mk(eeseq_pkg::CMD_DONE, 8'd0, eeseq_pkg::ST_BAD_ADDR);
                        n_res = 3'd1;
                    end
                    else if (length == 16'd0)
                    begin
                        q_data.ent[0] = mk(eeseq_pkg::CMD_DONE, 8'd0, eeseq_pkg::ST_OK);
                        n_res = 3'd1;
                    end
                    else
                    begin
                        addr_next = req_addr;
                        rem_next  = length;
                        if (operation == eeseq_pkg::OP_WRITE_REQ)
                        begin
                            pbl_next   = chunk(cfg.page_log2, req_addr16[7:0], length);
                            phase_next = eeseq_pkg::PH_WR_CTRL;
                        end
                        else
                        begin
                            pbl_next   = 9'd0;
                            phase_next = eeseq_pkg::PH_RD_CTRL;
                        end
                        q_data.ent[0] = mk(eeseq_pkg::CMD_START, 8'd0, eeseq_pkg::ST_OK);
                        q_data.ent[1] = mk(eeseq_pkg::CMD_WRITE,
                                           ctrl_byte(cfg.ctrl_wr, cfg.two_byte, req_addr16[15:8]),
                                           eeseq_pkg::ST_OK);
                        n_res = 3'd2;
                    end
                end
            end
            eeseq_pkg::OP_WR_DATA:
            begin
                if (phase_reg == eeseq_pkg::PH_WR_NEED)
                begin
                    q_data.ent[0] = mk(eeseq_pkg::CMD_WRITE, data_byte, eeseq_pkg::ST_OK);
                    n_res = 3'd1;
                    phase_next = eeseq_pkg::PH_WR_DACK;
                end
            end
            eeseq_pkg::OP_BUS_ACK:
            begin
                unique case (phase_reg)
                    eeseq_pkg::PH_RD_CTRL, eeseq_pkg::PH_RD_AHI, eeseq_pkg::PH_RD_ALO,
                    eeseq_pkg::PH_RD_CTRLRD:
                    begin
                        if (!ack)
                        begin
                            q_data.ent[0] = mk(eeseq_pkg::CMD_STOP, 8'd0, eeseq_pkg::ST_OK);
                            q_data.ent[1] = mk(eeseq_pkg::CMD_DONE, 8'd0, eeseq_pkg::ST_RD_NACK);
                            n_res = 3'd2;
                            phase_next = eeseq_pkg::PH_IDLE;
                        end
                        else if (phase_reg == eeseq_pkg::PH_RD_CTRL)
                        begin
                            q_data.ent[0] = mk(eeseq_pkg::CMD_WRITE,
                                               cfg.two_byte ? cur_addr16[15:8] : cur_addr16[7:0],
                                               eeseq_pkg::ST_OK);
                            n_res = 3'd1;
                            phase_next = cfg.two_byte ? eeseq_pkg::PH_RD_AHI
                                                      : eeseq_pkg::PH_RD_ALO;
                        end
                        else if (phase_reg == eeseq_pkg::PH_RD_AHI)
                        begin
                            q_data.ent[0] = mk(eeseq_pkg::CMD_WRITE, cur_addr16[7:0],
                                               eeseq_pkg::ST_OK);
                            n_res = 3'd1;
                            phase_next = eeseq_pkg::PH_RD_ALO;
                        end
                        else if (phase_reg == eeseq_pkg::PH_RD_ALO)
                        begin
                            // Repeated start, then the read control byte
                            q_data.ent[0] = mk(eeseq_pkg::CMD_START, 8'd0, eeseq_pkg::ST_OK);
                            q_data.ent[1] = mk(eeseq_pkg::CMD_WRITE,
                                               ctrl_byte(cfg.ctrl_rd, cfg.two_byte,
                                                         cur_addr16[15:8]),
                                               eeseq_pkg::ST_OK);
                            n_res = 3'd2;
                            phase_next = eeseq_pkg::PH_RD_CTRLRD;
                        end
                        else
                        begin
                            q_data.ent[0] = mk((rem_reg == 16'd1) ? eeseq_pkg::CMD_RNACK
                                                                  : eeseq_pkg::CMD_RACK,
                                               8'd0, eeseq_pkg::ST_OK);
                            n_res = 3'd1;
                            phase_next = eeseq_pkg::PH_RD_DATA;
                        end
                    end
                    eeseq_pkg::PH_WR_CTRL, eeseq_pkg::PH_WR_AHI, eeseq_pkg::PH_WR_ALO,
                    eeseq_pkg::PH_WR_DACK:
                    begin
                        if (!ack)
                        begin
                            q_data.ent[0] = mk(eeseq_pkg::CMD_STOP, 8'd0, eeseq_pkg::ST_OK);
                            q_data.ent[1] = mk(eeseq_pkg::CMD_DONE, 8'd0, eeseq_pkg::ST_WR_FAIL);
                            n_res = 3'd2;
                            phase_next = eeseq_pkg::PH_IDLE;
                        end
                        else if (phase_reg == eeseq_pkg::PH_WR_CTRL)
                        begin
                            q_data.ent[0] = mk(eeseq_pkg::CMD_WRITE,
                                               cfg.two_byte ? cur_addr16[15:8] : cur_addr16[7:0],
                                               eeseq_pkg::ST_OK);
                            n_res = 3'd1;
                            phase_next = cfg.two_byte ? eeseq_pkg::PH_WR_AHI
                                                      : eeseq_pkg::PH_WR_ALO;
                        end
                        else if (phase_reg == eeseq_pkg::PH_WR_AHI)
                        begin
                            q_data.ent[0] = mk(eeseq_pkg::CMD_WRITE, cur_addr16[7:0],
                                               eeseq_pkg::ST_OK);
                            n_res = 3'd1;
                            phase_next = eeseq_pkg::PH_WR_ALO;
                        end
                        else if (phase_reg == eeseq_pkg::PH_WR_ALO)
                        begin
                            q_data.ent[0] = mk(eeseq_pkg::CMD_NEED, 8'd0, eeseq_pkg::ST_OK);
                            n_res = 3'd1;
                            phase_next = eeseq_pkg::PH_WR_NEED;
                        end
                        else
                        begin
                            // Data byte acknowledged: step counters, close the page at its end
                            pbl_next = pbl_dec;
                            rem_next = rem_dec;
                            if (pbl_dec != 9'd0)
                            begin
                                addr_next = addr_inc[ADDR_WIDTH-1:0];
                                q_data.ent[0] = mk(eeseq_pkg::CMD_NEED, 8'd0, eeseq_pkg::ST_OK);
                                n_res = 3'd1;
                                phase_next = eeseq_pkg::PH_WR_NEED;
                            end
                            else
                            begin
                                addr_next = wrap_addr;
                                q_data.ent[0] = mk(eeseq_pkg::CMD_STOP, 8'd0, eeseq_pkg::ST_OK);
                                q_data.ent[1] = mk(eeseq_pkg::CMD_WAIT, 8'd0, eeseq_pkg::ST_OK);
                                if (rem_dec != 16'd0)
                                begin
                                    // Size the next page from the wrapped address
                                    pbl_next = chunk(cfg.page_log2, wrap_addr16[7:0], rem_dec);
                                    q_data.ent[2] = mk(eeseq_pkg::CMD_START, 8'd0,
                                                       eeseq_pkg::ST_OK);
                                    q_data.ent[3] = mk(eeseq_pkg::CMD_WRITE,
                                                       ctrl_byte(cfg.ctrl_wr, cfg.two_byte,
                                                                 wrap_addr16[15:8]),
                                                       eeseq_pkg::ST_OK);
                                    n_res = 3'd4;
                                    phase_next = eeseq_pkg::PH_WR_CTRL;
                                end
                                else
                                begin
                                    q_data.ent[2] = mk(eeseq_pkg::CMD_DONE, 8'd0,
                                                       eeseq_pkg::ST_OK);
                                    n_res = 3'd3;
                                    phase_next = eeseq_pkg::PH_IDLE;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        n_res = 3'd0;
                    end
                endcase
            end
            eeseq_pkg::OP_BUS_READ:
            begin
                if (phase_reg == eeseq_pkg::PH_RD_DATA)
                begin
                    rem_next = rem_dec;
                    q_data.ent[0] = mk(eeseq_pkg::CMD_DATA, data_byte, eeseq_pkg::ST_OK);
                    if (rem_dec != 16'd0)
                    begin
                        q_data.ent[1] = mk((rem_dec == 16'd1) ? eeseq_pkg::CMD_RNACK
                                                              : eeseq_pkg::CMD_RACK,
                                           8'd0, eeseq_pkg::ST_OK);
                        n_res = 3'd2;
                    end
                    else
                    begin
                        q_data.ent[1] = mk(eeseq_pkg::CMD_STOP, 8'd0, eeseq_pkg::ST_OK);
                        q_data.ent[2] = mk(eeseq_pkg::CMD_DONE, 8'd0, eeseq_pkg::ST_OK);
                        n_res = 3'd3;
                        phase_next = eeseq_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                n_res = 3'd0;
            end
        endcase
        q_data.last_idx = 2'(n_res - 3'd1);
        q_push = accept && (n_res != 3'd0);
    end

    // Hold the access state; update only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= eeseq_pkg::PH_IDLE;
            addr_reg  <= '0;
            rem_reg   <= '0;
            pbl_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            pbl_reg   <= pbl_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/eeseq_fifo.sv
// Short queue of result bursts between front end and back end.
// Uses eeseq_pkg for the burst type.
`default_nettype none

module eeseq_fifo #(
    parameter int DEPTH = eeseq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       wr_en,
    input  wire eeseq_pkg::burst_t    wr_data,
    output logic                      full,
    input  wire                       rd_en,
    output eeseq_pkg::burst_t         rd_data,
    output logic                      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    eeseq_pkg::burst_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Store pushed bursts
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/eeseq_back.sv
// Back end: unpacks queued bursts and presents one result word per cycle
// on the output queue interface while pop is high. Uses eeseq_pkg.
`default_nettype none

module eeseq_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire eeseq_pkg::burst_t   q_data,
    input  wire                      q_empty,
    output logic                     q_pop,
    output logic                     empty,
    input  wire                      pop,
    output logic [3:0]               command,
    output logic [7:0]               byte_value,
    output logic [1:0]               status,
    output logic                     last
);

    eeseq_pkg::burst_t  rec_reg;
    logic [1:0]         idx_reg;
    logic               valid_reg;
    logic               take;
    eeseq_pkg::res_t    cur;

    assign cur        = rec_reg.ent[idx_reg];
    assign empty      = !valid_reg;
    assign command    = cur.cmd;
    assign byte_value = cur.byte_value;
    assign status     = cur.status;
    assign last       = (idx_reg == rec_reg.last_idx);

    // Load the next burst when nothing is shown or the final word leaves
    assign take  = pop && valid_reg;
    assign q_pop = !q_empty && (!valid_reg || (take && last));

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rec_reg <= q_data;
        end
    end

    // Step through the entries of the shown burst
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
                idx_reg   <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2c_eeprom_access_sequencer.sv
// Top level of the serial EEPROM access sequencer: configuration registers,
// front end, burst queue and back end. Uses eeseq_pkg and the eeseq_* modules.
//
//   Channel   Handshake          Payload
//   input     push / full        operation, address, length, data_byte, ack
//   result    empty / pop        command, byte_value, status, last
//   config    cfg_we             cfg_index, cfg_data
//
// An input word is taken whenever the burst queue has room; the front end
// turns it into up to four results in the cycle that it is taken.
// The back end shows one result per cycle while pop is high, so a word with
// k results holds the result side until all are popped; the two-entry burst
// queue absorbs the rest. Words that cause no result are taken and dropped
// without using the queue. Ready right after reset; no clearing pass.
`default_nettype none

module i2c_eeprom_access_sequencer #(
    parameter int ADDR_WIDTH  = eeseq_pkg::ADDR_WIDTH_DEF,
    parameter int QUEUE_DEPTH = eeseq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // input words
    input  wire         push,
    output logic        full,
    input  wire  [2:0]  operation,
    input  wire  [15:0] address,
    input  wire  [15:0] length,
    input  wire  [7:0]  data_byte,
    input  wire         ack,
    // result words
    output logic        empty,
    input  wire         pop,
    output logic [3:0]  command,
    output logic [7:0]  byte_value,
    output logic [1:0]  status,
    output logic        last,
    // configuration writes
    input  wire         cfg_we,
    input  wire  [eeseq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [eeseq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    eeseq_pkg::cfg_t    cfg_reg;
    eeseq_pkg::burst_t  fq_wdata, fq_rdata;
    logic               accept;
    logic               q_push;
    logic               q_pop;
    logic               q_empty;

    assign accept = push && !full;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chip_size <= 17'd256;
            cfg_reg.page_log2 <= 4'd4;
            cfg_reg.ctrl_wr   <= 8'd160;
            cfg_reg.ctrl_rd   <= 8'd161;
            cfg_reg.two_byte  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eeseq_pkg::REG_CHIP_SIZE: cfg_reg.chip_size <= cfg_data[16:0];
                eeseq_pkg::REG_PAGE_LOG2: cfg_reg.page_log2 <= cfg_data[3:0];
                eeseq_pkg::REG_CTRL_WR:   cfg_reg.ctrl_wr   <= cfg_data[7:0];
                eeseq_pkg::REG_CTRL_RD:   cfg_reg.ctrl_rd   <= cfg_data[7:0];
                eeseq_pkg::REG_TWO_BYTE:  cfg_reg.two_byte  <= cfg_data[0];
                default:                  cfg_reg           <= cfg_reg;
            endcase
        end
    end

    eeseq_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .operation (operation),
        .address   (address),
        .length    (length),
        .data_byte (data_byte),
        .ack       (ack),
        .q_push    (q_push),
        .q_data    (fq_wdata)
    );

    eeseq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (fq_wdata),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (fq_rdata),
        .empty   (q_empty)
    );

    eeseq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (fq_rdata),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .command    (command),
        .byte_value (byte_value),
        .status     (status),
        .last       (last)
    );

`ifndef NO_ASSERTIONS
    // A word that is not the final one of its burst leaves a follower behind
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=> !empty)
        else $error("burst ended early");

    // Done always closes the results of its word
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && command == eeseq_pkg::CMD_DONE) |-> last)
        else $error("done word not marked last");

    // Status carries a code only together with done
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && command != eeseq_pkg::CMD_DONE) |-> status == eeseq_pkg::ST_OK)
        else $error("status set without done");

    // Queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !full)
        else $error("burst queue overflow");
`endif

endmodule

`default_nettype wire
